### rtl/ecg_rpeak_heart_rate_macros.svh
// Assertion macros for the R-peak detector.
// Used by the top level only; expects clk and rst in scope.
`ifndef ECG_RPEAK_HEART_RATE_MACROS_SVH
`define ECG_RPEAK_HEART_RATE_MACROS_SVH

// same-cycle implication
`define ECG_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ECG_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/ecgrp_pkg.sv
// Shared types and constants for the R-peak detector.
// No dependencies.
package ecgrp_pkg;

  // dividend is sample_rate * 60, at most 8191 * 60 < 2**19
  localparam int DIV_W = 19;
  localparam int RATE_W = 16;
  localparam int CNT_W = $clog2(DIV_W);

  localparam logic signed [31:0] START_THRESHOLD_RESET = 32'sd350;
  localparam logic [12:0] SAMPLE_RATE_RESET = 13'd250;

  localparam logic [1:0] REG_START_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_SAMPLE_RATE = 2'd1;

  typedef struct packed {
    logic start;
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic [RATE_W-1:0] quotient;
  } div_rsp_t;

endpackage

### rtl/ecgrp_div.sv
// Bit-serial restoring divider, one quotient bit per cycle, saturating result.
// Depends on ecgrp_pkg.
module ecgrp_div (
  input  logic                clk,
  input  logic                rst,
  input  ecgrp_pkg::div_req_t req,
  output ecgrp_pkg::div_rsp_t rsp
);
  import ecgrp_pkg::*;

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DIV_W-1:0] divisor;
  logic [DIV_W-1:0] dvd;
  logic [DIV_W-1:0] quot;
  logic [DIV_W-1:0] rem;
  logic [DIV_W:0]   shifted;
  logic [DIV_W+1:0] diff;
  logic             qbit;
  logic             done;

  assign shifted = {rem, dvd[DIV_W-1]};
  assign diff = {1'b0, shifted} - {2'b00, divisor};
  assign qbit = !diff[DIV_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt <= '0;
        divisor <= req.divisor;
        dvd <= req.dividend;
        rem <= '0;
        quot <= '0;
      end else if (busy) begin
        // shift one dividend bit in, keep the trial remainder when it fits
        rem <= qbit ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
        quot <= {quot[DIV_W-2:0], qbit};
        dvd <= {dvd[DIV_W-2:0], 1'b0};
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quotient = (quot[DIV_W-1:RATE_W] != '0) ? {RATE_W{1'b1}} : quot[RATE_W-1:0];

endmodule

### rtl/ecg_rpeak_heart_rate.sv
// R-peak detector with heart-rate output. One sample is taken per beat while the block is idle;
// a sample that does not end a peak goes through S_EVAL and S_FINISH, one that ends a peak also
// through S_MUL_A, S_MUL_B and, if in range, the bit-serial divider for 60*sample_rate/distance.
// A finished result waits in the output register while the next sample is already accepted.
// Writing start_threshold also reloads the running threshold.
module ecg_rpeak_heart_rate #(
  parameter int WRAP_LENGTH = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic signed [31:0] sample,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [ecgrp_pkg::RATE_W-1:0] heart_rate,
  output logic        beat
);
  import ecgrp_pkg::*;

  localparam int POS_W = $clog2(WRAP_LENGTH);
  localparam logic signed [31:0] S32_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] S32_MIN = 32'sh80000000;

  typedef enum logic [2:0] {S_IDLE, S_EVAL, S_MUL_A, S_MUL_B, S_DIV, S_FINISH} state_t;

  state_t state;

  logic signed [31:0] start_threshold;
  logic [12:0]        sample_rate;
  logic signed [31:0] level;
  logic signed [31:0] peak_value;
  logic [POS_W-1:0]   peak_position;
  logic signed [31:0] last_peak_position;
  logic [POS_W-1:0]   position;
  logic signed [31:0] previous_sample;
  logic [RATE_W-1:0]  rate_store;
  logic signed [31:0] cur;
  logic               beat_pend;
  logic signed [37:0] acc;
  logic signed [34:0] pk7;
  logic signed [33:0] span;

  logic signed [37:0] lvl_ext;
  logic signed [34:0] pk_ext;
  logic signed [38:0] sum;
  logic signed [32:0] level_new;
  logic signed [33:0] span_next;
  logic               span_pos;
  logic               span_small;
  logic [POS_W:0]     pos_inc;
  logic signed [32:0] lpp_wrap;
  logic [DIV_W-1:0]   dividend;
  logic               out_free;
  div_req_t           div_req;
  div_rsp_t           div_rsp;

  assign lvl_ext = {{6{level[31]}}, level};
  assign pk_ext = {{3{peak_value[31]}}, peak_value};
  assign sum = {acc[37], acc} + {{4{pk7[34]}}, pk7};
  assign level_new = sum[38:6];
  assign span_next = $signed({{(34 - POS_W){1'b0}}, peak_position})
                   - $signed({{2{last_peak_position[31]}}, last_peak_position});
  assign span_pos = !span[33] && (span != '0);
  assign span_small = (span[33:DIV_W] == '0);
  assign pos_inc = {1'b0, position} + 1'b1;
  assign lpp_wrap = $signed({last_peak_position[31], last_peak_position})
                  - $signed(33'(WRAP_LENGTH));
  assign dividend = ({6'b0, sample_rate} << 6) - ({6'b0, sample_rate} << 2);
  assign out_free = !out_valid || !out_stall;

  assign in_stall = (state != S_IDLE);

  assign div_req.start = (state == S_MUL_B) && span_pos && span_small;
  assign div_req.dividend = dividend;
  assign div_req.divisor = span[DIV_W-1:0];

  ecgrp_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      start_threshold <= START_THRESHOLD_RESET;
      sample_rate <= SAMPLE_RATE_RESET;
      level <= START_THRESHOLD_RESET;
      peak_value <= '0;
      peak_position <= '0;
      last_peak_position <= -32'sd1;
      position <= '0;
      previous_sample <= '0;
      rate_store <= '0;
      beat_pend <= 1'b0;
      out_valid <= 1'b0;
      heart_rate <= '0;
      beat <= 1'b0;
    end else begin
      // a finishing beat reloads the output register itself
      if (out_valid && !out_stall && (state != S_FINISH)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            cur <= sample;
            beat_pend <= 1'b0;
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          priority if (cur >= level) begin
            if (cur >= peak_value) begin
              peak_value <= cur;
              peak_position <= position;
            end
            state <= S_FINISH;
          end else if (previous_sample >= level) begin
            span <= span_next;
            state <= S_MUL_A;
          end else begin
            if (level != S32_MIN) begin
              level <= level - 32'sd1;
            end
            peak_value <= '0;
            state <= S_FINISH;
          end
        end
        S_MUL_A: begin
          acc <= (lvl_ext <<< 5) + (lvl_ext <<< 4) + lvl_ext;
          pk7 <= (pk_ext <<< 3) - pk_ext;
          last_peak_position <= $signed({{(32 - POS_W){1'b0}}, peak_position});
          peak_value <= '0;
          state <= S_MUL_B;
        end
        S_MUL_B: begin
          if (level_new[32] != level_new[31]) begin
            level <= level_new[32] ? S32_MIN : S32_MAX;
          end else begin
            level <= level_new[31:0];
          end
          priority if (span_pos && span_small) begin
            state <= S_DIV;
          end else if (span_pos) begin
            // distance beyond the dividend range: quotient is zero
            rate_store <= '0;
            beat_pend <= 1'b1;
            state <= S_FINISH;
          end else begin
            state <= S_FINISH;
          end
        end
        S_DIV: begin
          if (div_rsp.done) begin
            rate_store <= div_rsp.quotient;
            beat_pend <= 1'b1;
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            if (pos_inc >= (POS_W + 1)'(WRAP_LENGTH)) begin
              position <= '0;
              // rebase the previous peak, saturating at the bottom of the range
              if (lpp_wrap[32] != lpp_wrap[31]) begin
                last_peak_position <= S32_MIN;
              end else begin
                last_peak_position <= lpp_wrap[31:0];
              end
            end else begin
              position <= pos_inc[POS_W-1:0];
            end
            previous_sample <= cur;
            heart_rate <= rate_store;
            beat <= beat_pend;
            out_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (cfg_we) begin
        if (cfg_index == REG_START_THRESHOLD) begin
          start_threshold <= cfg_data;
          level <= cfg_data;
        end else if (cfg_index == REG_SAMPLE_RATE) begin
          sample_rate <= cfg_data[12:0];
        end
      end
    end
  end

`include "ecg_rpeak_heart_rate_macros.svh"

  `ECG_ASSERT_IMP(a_div_done_waited, div_rsp.done, state == S_DIV, "divider finished unasked")
  `ECG_ASSERT_NXT(a_accept_eval, in_valid && !in_stall, state == S_EVAL, "accepted beat not evaluated")
  `ECG_ASSERT_IMP(a_result_from_finish, $rose(out_valid), $past(state) == S_FINISH, "result without finish")
  `ECG_ASSERT_NXT(a_level_tracks_cfg, cfg_we && cfg_index == REG_START_THRESHOLD, level == start_threshold, "threshold not reloaded")

endmodule

### verif/tb_top.sv
// Self-checking bench for ecg_rpeak_heart_rate: a queued beat driver, a monitor and a
// cycle-free predictor of threshold, peak tracking and heart rate. Needs ecgrp_pkg and the RTL.
module tb_top;
  import ecgrp_pkg::*;

  localparam int WRAP_LEN = 1024;
  localparam logic [1:0] REG_SPARE_A = 2'd2;
  localparam logic [1:0] REG_SPARE_B = 2'd3;
  localparam int SETTLE_CYCLES = 40;
  localparam longint S32_HI = 64'sd2147483647;
  localparam longint S32_LO = -64'sd2147483648;

  typedef struct packed {
    logic [RATE_W-1:0] rate;
    logic              beat;
  } hr_out_t;

  logic clk;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] sample = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [RATE_W-1:0] heart_rate;
  logic beat;

  ecg_rpeak_heart_rate #(.WRAP_LENGTH(WRAP_LEN)) dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .sample(sample),
    .out_valid(out_valid), .out_stall(out_stall),
    .heart_rate(heart_rate), .beat(beat)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // predictor state
  logic signed [31:0] thr_cfg;
  logic [12:0]        rate_cfg;
  logic signed [31:0] level_q;
  logic signed [31:0] peak_q;
  logic [15:0]        peak_pos_q;
  logic signed [31:0] last_peak_q;
  logic [15:0]        pos_q;
  logic signed [31:0] prev_q;
  logic [RATE_W-1:0]  bpm_q;

  logic signed [31:0] sample_backlog[$];
  hr_out_t            hr_due[$];
  int unsigned        err_count = 0;
  int unsigned        idle_left = 0;
  int unsigned        stall_left = 0;
  bit                 src_calm = 1'b0;
  bit                 sink_calm = 1'b0;

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > S32_HI) return S32_HI[31:0];
    if (v < S32_LO) return S32_LO[31:0];
    return v[31:0];
  endfunction

  function automatic void reset_tracker();
    thr_cfg = START_THRESHOLD_RESET;
    rate_cfg = SAMPLE_RATE_RESET;
    level_q = thr_cfg;
    peak_q = '0;
    peak_pos_q = '0;
    last_peak_q = -32'sd1;
    pos_q = '0;
    prev_q = '0;
    bpm_q = '0;
  endfunction

  function automatic void apply_reg(logic [1:0] idx, logic [31:0] data);
    case (idx)
      REG_START_THRESHOLD: begin
        thr_cfg = data;
        level_q = data;
      end
      REG_SAMPLE_RATE: begin
        rate_cfg = data[12:0];
      end
      default: begin
      end
    endcase
  endfunction

  // advance the tracker by one sample and return the rate it reports
  function automatic hr_out_t track_sample(logic signed [31:0] s);
    hr_out_t r;
    longint span;
    longint quo;
    longint acc;
    int unsigned npos;
    r.beat = 1'b0;
    if (s >= level_q) begin
      if (s >= peak_q) begin
        peak_q = s;
        peak_pos_q = pos_q;
      end
    end else if (prev_q >= level_q) begin
      span = longint'(peak_pos_q) - longint'(last_peak_q);
      if (span > 0) begin
        quo = (longint'(rate_cfg) * 60) / span;
        if (quo > 65535) quo = 65535;
        bpm_q = quo[RATE_W-1:0];
        r.beat = 1'b1;
      end
      acc = longint'(level_q) * 49 + longint'(peak_q) * 7;
      level_q = clamp32(acc >>> 6);
      last_peak_q = {16'd0, peak_pos_q};
      peak_q = '0;
    end else begin
      level_q = clamp32(longint'(level_q) - 1);
      peak_q = '0;
    end
    npos = pos_q + 1;
    if (npos >= WRAP_LEN) begin
      npos = 0;
      last_peak_q = clamp32(longint'(last_peak_q) - WRAP_LEN);
    end
    pos_q = npos[15:0];
    prev_q = s;
    r.rate = bpm_q;
    return r;
  endfunction

  // mostly short gaps, a few long ones, none in a calm stretch
  function automatic int unsigned pick_idle(bit calm);
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  always @(posedge clk) begin : drive_p
    logic fire;
    fire = in_valid && !in_stall;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (fire) begin
        hr_due.push_back(track_sample(sample));
      end
      if (!in_valid || fire) begin
        if (idle_left > 0) begin
          idle_left--;
          in_valid <= 1'b0;
        end else if (sample_backlog.size() > 0) begin
          sample <= sample_backlog.pop_front();
          in_valid <= 1'b1;
          idle_left = pick_idle(src_calm);
        end else begin
          in_valid <= 1'b0;
        end
      end
      if ($urandom_range(0, 255) == 0) src_calm = !src_calm;
    end
  end

  always @(posedge clk) begin : watch_p
    hr_out_t want;
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (hr_due.size() == 0) begin
          $display("%0t: unexpected result heart_rate=%0d beat=%0d", $time, heart_rate, beat);
          err_count++;
        end else begin
          want = hr_due.pop_front();
          if (heart_rate !== want.rate) begin
            $display("%0t: heart_rate expected %0d actual %0d", $time, want.rate, heart_rate);
            err_count++;
          end
          if (beat !== want.beat) begin
            $display("%0t: beat expected %0d actual %0d", $time, want.beat, beat);
            err_count++;
          end
        end
      end
      if (stall_left == 0 && $urandom_range(0, 3) == 0) stall_left = pick_idle(sink_calm);
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
      if ($urandom_range(0, 255) == 0) sink_calm = !sink_calm;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    apply_reg(idx, data);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // hold until every beat is out and the divider has had time to finish
  task automatic drain();
    while (sample_backlog.size() != 0 || in_valid || hr_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic signed [31:0] near(logic signed [31:0] base, longint lo, longint hi);
    longint off;
    off = lo + longint'($urandom_range(0, int'(hi - lo)));
    return clamp32(longint'(base) + off);
  endfunction

  // synthetic ECG around the threshold: baseline, narrow R peaks, some raw noise
  task automatic queue_ecg(logic signed [31:0] thr, int n);
    int count;
    int amp;
    int flat;
    int width;
    count = 0;
    amp = $urandom_range(200, 20000);
    while (count < n) begin
      if ($urandom_range(0, 99) < 12) begin
        sample_backlog.push_back($urandom);
        count++;
      end else begin
        flat = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : $urandom_range(4, 150);
        if ($urandom_range(0, 40) == 0) flat = $urandom_range(300, 600);
        repeat (flat) begin
          if (count < n) begin
            sample_backlog.push_back(near(thr, -amp, -amp / 4));
            count++;
          end
        end
        width = $urandom_range(1, 6);
        repeat (width) begin
          if (count < n) begin
            sample_backlog.push_back(near(thr, 0, 2 * amp));
            count++;
          end
        end
      end
    end
  endtask

  initial begin : main_p
    logic signed [31:0] thr;
    logic [12:0] rate;
    reset_tracker();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset settings: extremes of the sample and a couple of ordinary peaks
    sample_backlog = '{32'sd0, 32'sh7fffffff, 32'sh80000000, -32'sd1, 32'sd1,
                       32'sd500, 32'sd900, 32'sd700, -32'sd20};
    drain();

    // zero rate, negative threshold: second drop has a stale peak position
    write_reg(REG_SAMPLE_RATE, 32'd0);
    write_reg(REG_START_THRESHOLD, 32'sd5);
    write_reg(REG_START_THRESHOLD, -32'sd100);
    write_reg(REG_SPARE_A, $urandom);
    sample_backlog = '{32'sd10, -32'sd200, -32'sd50, -32'sd200};
    drain();

    // top rate with peaks close together saturates the quotient
    write_reg(REG_SAMPLE_RATE, 32'd8191);
    write_reg(REG_START_THRESHOLD, 32'sd0);
    write_reg(REG_SPARE_B, $urandom);
    sample_backlog = '{32'sd100, -32'sd1, 32'sd100, -32'sd1};
    drain();

    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: begin thr = START_THRESHOLD_RESET; rate = SAMPLE_RATE_RESET; end
        1: begin thr = 32'sh7fffffff; rate = 13'd1; end
        2: begin thr = 32'sh80000000; rate = 13'd8191; end
        3: begin thr = 32'sd0; rate = 13'd0; end
        4: begin thr = near(32'sd0, -2000, 2000); rate = 13'd4096; end
        5: begin thr = $urandom; rate = 13'($urandom); end
        default: begin
          thr = near(32'sd0, -100000, 100000);
          rate = $urandom_range(1, 4096);
        end
      endcase
      if ($urandom_range(0, 1) == 0) begin
        write_reg(REG_START_THRESHOLD, thr);
        write_reg(REG_SAMPLE_RATE, {19'($urandom), rate});
      end else begin
        write_reg(REG_SAMPLE_RATE, {19'd0, rate});
        write_reg(REG_START_THRESHOLD, thr);
      end
      if ($urandom_range(0, 2) == 0) write_reg(REG_SPARE_A, $urandom);
      queue_ecg(thr, 115);
      drain();
    end

    if (err_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin : limit_p
    #10000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
